@@ rtl/quaternion_to_euler_assert.svh @@
// assertion macros for the quaternion to euler checker
// expects clk and rst_n in the scope where the macros are used
`ifndef QUATERNION_TO_EULER_ASSERT_SVH
`define QUATERNION_TO_EULER_ASSERT_SVH

// same-cycle implication
`define Q2E_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define Q2E_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/q2e_pkg.sv @@
// shared widths, constants, types and tables for the quaternion to euler block
// no dependencies
`timescale 1ns / 1ps

package q2e_pkg;

    localparam int QW                = 16;
    localparam int PROD_W            = 2 * QW;
    localparam int ARG_W             = 34;
    localparam int MAG_W             = 30;
    localparam int SQ_W              = 2 * MAG_W;
    localparam int RAD_W             = SQ_W + 1;
    localparam int ROOT_STEPS        = MAG_W + 1;
    localparam int XY_W              = 37;
    localparam int Z_W               = 34;
    localparam int ANG_W             = 16;
    localparam int PITCH_W           = 15;
    localparam int ATAN_LEN          = 24;
    localparam int ATAN_IDX_W        = $clog2(ATAN_LEN);
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ROUND_SHIFT       = 17;
    localparam int NLANE             = 3;

    localparam int LANE_ROLL  = 0;
    localparam int LANE_PITCH = 1;
    localparam int LANE_YAW   = 2;

    localparam logic signed [ARG_W-1:0] ONE_Q30     = 34'sd1073741824;
    localparam logic signed [Z_W-1:0]   HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [Z_W-1:0]   ROUND_HALF  = 34'sd65536;
    localparam logic signed [ANG_W-1:0] PI_Q13      = 16'sd25736;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q13 = 16'sd12868;

    typedef struct packed {
        logic signed [ARG_W-1:0] sr;
        logic signed [ARG_W-1:0] cr;
        logic signed [ARG_W-1:0] sy;
        logic signed [ARG_W-1:0] cy;
        logic signed [ARG_W-1:0] sp;
        logic                    clamp;
    } side_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   zero;
        logic                   clamp;
        logic                   neg;
    } cord_t;

    // arctangent of 2^-i at scale 2^30
    function automatic logic signed [Z_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [Z_W-1:0] a;
        case (idx)
            5'd0:    a = 34'sd843314857;
            5'd1:    a = 34'sd497837829;
            5'd2:    a = 34'sd263043837;
            5'd3:    a = 34'sd133525159;
            5'd4:    a = 34'sd67021687;
            5'd5:    a = 34'sd33543516;
            5'd6:    a = 34'sd16775851;
            5'd7:    a = 34'sd8388437;
            5'd8:    a = 34'sd4194283;
            5'd9:    a = 34'sd2097149;
            5'd10:   a = 34'sd1048576;
            5'd11:   a = 34'sd524288;
            5'd12:   a = 34'sd262144;
            5'd13:   a = 34'sd131072;
            5'd14:   a = 34'sd65536;
            5'd15:   a = 34'sd32768;
            5'd16:   a = 34'sd16384;
            5'd17:   a = 34'sd8192;
            5'd18:   a = 34'sd4096;
            5'd19:   a = 34'sd2048;
            5'd20:   a = 34'sd1024;
            5'd21:   a = 34'sd512;
            5'd22:   a = 34'sd256;
            5'd23:   a = 34'sd128;
            default: a = '0;
        endcase
        return a;
    endfunction

    // move the vector into the right half plane and flag the all-zero case
    function automatic cord_t cord_prep(input logic signed [ARG_W-1:0] ya,
                                        input logic signed [ARG_W-1:0] xa);
        cord_t c;
        c.zero  = (ya == '0) && (xa == '0);
        c.clamp = 1'b0;
        c.neg   = 1'b0;
        if (xa < 0)
        begin
            if (ya >= 0)
            begin
                c.x = XY_W'(ya);
                c.y = -XY_W'(xa);
                c.z = HALF_PI_Q30;
            end
            else
            begin
                c.x = -XY_W'(ya);
                c.y = XY_W'(xa);
                c.z = -HALF_PI_Q30;
            end
        end
        else
        begin
            c.x = XY_W'(xa);
            c.y = XY_W'(ya);
            c.z = '0;
        end
        return c;
    endfunction

endpackage

@@ rtl/q2e_front.sv @@
// front stages: products, product sums, pitch magnitude, square and radicand
// depends on q2e_pkg
`timescale 1ns / 1ps

module q2e_front
    import q2e_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [QW-1:0]    quat_w,
    input  logic signed [QW-1:0]    quat_x,
    input  logic signed [QW-1:0]    quat_y,
    input  logic signed [QW-1:0]    quat_z,
    output logic                    out_valid,
    output logic [RAD_W-1:0]        rad,
    output side_t                   side
);

    logic signed [PROD_W-1:0] p_wx_reg, p_yz_reg, p_xx_reg, p_yy_reg, p_wz_reg;
    logic signed [PROD_W-1:0] p_xy_reg, p_zz_reg, p_wy_reg, p_zx_reg;
    logic                     v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    side_t                    s2_reg, s3_reg, s4_reg, s5_reg;
    side_t                    s2_next, s3_next;
    logic [MAG_W-1:0]         mag3_reg, mag3_next;
    logic [SQ_W-1:0]          sq4_reg;
    logic [RAD_W-1:0]         rad5_reg;
    logic signed [ARG_W-1:0]  neg_sp;

    always_comb
    begin
        s2_next.sr    = (ARG_W'(p_wx_reg) + ARG_W'(p_yz_reg)) <<< 1;
        s2_next.cr    = ONE_Q30 - ((ARG_W'(p_xx_reg) + ARG_W'(p_yy_reg)) <<< 1);
        s2_next.sy    = (ARG_W'(p_wz_reg) + ARG_W'(p_xy_reg)) <<< 1;
        s2_next.cy    = ONE_Q30 - ((ARG_W'(p_yy_reg) + ARG_W'(p_zz_reg)) <<< 1);
        s2_next.sp    = (ARG_W'(p_wy_reg) - ARG_W'(p_zx_reg)) <<< 1;
        s2_next.clamp = 1'b0;
    end

    always_comb
    begin
        neg_sp        = -s2_reg.sp;
        s3_next       = s2_reg;
        s3_next.clamp = (s2_reg.sp >= ONE_Q30) || (s2_reg.sp <= -ONE_Q30);
        mag3_next     = s2_reg.sp[ARG_W-1] ? neg_sp[MAG_W-1:0] : s2_reg.sp[MAG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_wx_reg <= PROD_W'(quat_w) * PROD_W'(quat_x);
            p_yz_reg <= PROD_W'(quat_y) * PROD_W'(quat_z);
            p_xx_reg <= PROD_W'(quat_x) * PROD_W'(quat_x);
            p_yy_reg <= PROD_W'(quat_y) * PROD_W'(quat_y);
            p_wz_reg <= PROD_W'(quat_w) * PROD_W'(quat_z);
            p_xy_reg <= PROD_W'(quat_x) * PROD_W'(quat_y);
            p_zz_reg <= PROD_W'(quat_z) * PROD_W'(quat_z);
            p_wy_reg <= PROD_W'(quat_w) * PROD_W'(quat_y);
            p_zx_reg <= PROD_W'(quat_z) * PROD_W'(quat_x);
            s2_reg   <= s2_next;
            s3_reg   <= s3_next;
            mag3_reg <= mag3_next;
            s4_reg   <= s3_reg;
            sq4_reg  <= SQ_W'(mag3_reg) * SQ_W'(mag3_reg);
            s5_reg   <= s4_reg;
            rad5_reg <= (RAD_W'(1) << SQ_W) - RAD_W'(sq4_reg);
        end
    end

    assign out_valid = v5_reg;
    assign rad       = rad5_reg;
    assign side      = s5_reg;

endmodule

@@ rtl/q2e_sqrt_cell.sv @@
// one digit step of the integer square root, with the argument sums riding along
// depends on q2e_pkg
`timescale 1ns / 1ps

module q2e_sqrt_cell
    import q2e_pkg::*;
#(
    parameter int K = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [RAD_W-1:0] in_v,
    input  logic [RAD_W-1:0] in_r,
    input  side_t            in_side,
    output logic             out_valid,
    output logic [RAD_W-1:0] out_v,
    output logic [RAD_W-1:0] out_r,
    output side_t            out_side
);

    localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2 * K);

    logic             valid_reg;
    logic [RAD_W-1:0] v_reg, v_next;
    logic [RAD_W-1:0] r_reg, r_next;
    side_t            side_reg;
    logic [RAD_W:0]   trial;

    always_comb
    begin
        trial = {1'b0, in_r} + {1'b0, BIT};
        if ({1'b0, in_v} >= trial)
        begin
            v_next = in_v - trial[RAD_W-1:0];
            r_next = (in_r >> 1) + BIT;
        end
        else
        begin
            v_next = in_v;
            r_next = in_r >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg    <= v_next;
            r_reg    <= r_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_v     = v_reg;
    assign out_r     = r_reg;
    assign out_side  = side_reg;

endmodule

@@ rtl/q2e_cordic_cell.sv @@
// one vectoring cordic step for the roll, pitch and yaw lanes
// depends on q2e_pkg
`timescale 1ns / 1ps

module q2e_cordic_cell
    import q2e_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  cord_t in_lane [NLANE],
    output logic  out_valid,
    output cord_t out_lane [NLANE]
);

    localparam logic signed [Z_W-1:0] ANGLE = atan_q30(ATAN_IDX_W'(IDX));

    logic                   valid_reg;
    cord_t                  lane_reg  [NLANE];
    cord_t                  lane_next [NLANE];
    logic signed [XY_W-1:0] dx [NLANE];
    logic signed [XY_W-1:0] dy [NLANE];

    always_comb
    begin
        for (int i = 0; i < NLANE; i++)
        begin
            dx[i]        = in_lane[i].y >>> IDX;
            dy[i]        = in_lane[i].x >>> IDX;
            lane_next[i] = in_lane[i];
            if (!in_lane[i].y[XY_W-1])
            begin
                lane_next[i].x = in_lane[i].x + dx[i];
                lane_next[i].y = in_lane[i].y - dy[i];
                lane_next[i].z = in_lane[i].z + ANGLE;
            end
            else
            begin
                lane_next[i].x = in_lane[i].x - dx[i];
                lane_next[i].y = in_lane[i].y + dy[i];
                lane_next[i].z = in_lane[i].z - ANGLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_lane  = lane_reg;

endmodule

@@ rtl/quaternion_to_euler.sv @@
// quaternion (w, x, y, z) to zyx euler angles, fully pipelined
// depends on q2e_pkg, q2e_front, q2e_sqrt_cell, q2e_cordic_cell
//
//  channel   signals                                  direction
//  quat      quat_valid quat_ready quat_w..quat_z     in
//  euler     euler_valid euler_ready roll pitch yaw   out
//            pitch_clamped
//
// one item per cycle while the output is not stalled; the path runs through
// 5 front stages, 31 square root digit cells, one setup stage,
// the cordic cells and the output register
// a stalled result at the output freezes the whole pipeline in place
// reset clears only the valid bits
`timescale 1ns / 1ps

module quaternion_to_euler
    import q2e_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      quat_valid,
    output logic                      quat_ready,
    input  logic signed [QW-1:0]      quat_w,
    input  logic signed [QW-1:0]      quat_x,
    input  logic signed [QW-1:0]      quat_y,
    input  logic signed [QW-1:0]      quat_z,
    output logic                      euler_valid,
    input  logic                      euler_ready,
    output logic signed [ANG_W-1:0]   roll,
    output logic signed [PITCH_W-1:0] pitch,
    output logic signed [ANG_W-1:0]   yaw,
    output logic                      pitch_clamped
);

    logic             en;
    logic             sq_valid [ROOT_STEPS+1];
    logic [RAD_W-1:0] sq_v     [ROOT_STEPS+1];
    logic [RAD_W-1:0] sq_r     [ROOT_STEPS+1];
    side_t            sq_side  [ROOT_STEPS+1];

    logic             cv [CORDIC_STAGES+1];
    cord_t            cl [CORDIC_STAGES+1][NLANE];

    logic                      prep_valid_reg;
    cord_t                     prep_reg  [NLANE];
    cord_t                     prep_next [NLANE];
    logic signed [ARG_W-1:0]   root_arg;
    side_t                     fin_side;

    logic                      out_valid_reg;
    logic signed [ANG_W-1:0]   roll_reg, yaw_reg, roll_next, yaw_next;
    logic signed [PITCH_W-1:0] pitch_reg, pitch_next;
    logic                      clamped_reg;
    logic signed [ANG_W-1:0]   pitch_wide;

    function automatic logic signed [ANG_W-1:0] to_angle(input cord_t c,
                                                         input logic signed [ANG_W-1:0] lim);
        logic signed [Z_W-1:0] zt;
        logic signed [Z_W-1:0] rr;
        logic signed [Z_W-1:0] lim_ext;
        logic signed [ANG_W-1:0] a;
        zt      = c.z + ROUND_HALF;
        rr      = zt >>> ROUND_SHIFT;
        lim_ext = Z_W'(lim);
        if (c.zero)
            a = '0;
        else if (rr > lim_ext)
            a = lim;
        else if (rr < -lim_ext)
            a = -lim;
        else
            a = rr[ANG_W-1:0];
        return a;
    endfunction

    assign en         = !out_valid_reg || euler_ready;
    assign quat_ready = en;

    q2e_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (quat_valid),
        .quat_w    (quat_w),
        .quat_x    (quat_x),
        .quat_y    (quat_y),
        .quat_z    (quat_z),
        .out_valid (sq_valid[0]),
        .rad       (sq_v[0]),
        .side      (sq_side[0])
    );

    assign sq_r[0] = '0;

    for (genvar k = 0; k < ROOT_STEPS; k++)
    begin : g_sqrt
        q2e_sqrt_cell #(
            .K (ROOT_STEPS - 1 - k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (sq_valid[k]),
            .in_v      (sq_v[k]),
            .in_r      (sq_r[k]),
            .in_side   (sq_side[k]),
            .out_valid (sq_valid[k+1]),
            .out_v     (sq_v[k+1]),
            .out_r     (sq_r[k+1]),
            .out_side  (sq_side[k+1])
        );
    end

    always_comb
    begin
        fin_side   = sq_side[ROOT_STEPS];
        root_arg   = $signed(ARG_W'(sq_r[ROOT_STEPS][ROOT_STEPS-1:0]));
        prep_next[LANE_ROLL]       = cord_prep(fin_side.sr, fin_side.cr);
        prep_next[LANE_YAW]        = cord_prep(fin_side.sy, fin_side.cy);
        prep_next[LANE_PITCH]      = cord_prep(fin_side.sp, root_arg);
        prep_next[LANE_PITCH].clamp = fin_side.clamp;
        prep_next[LANE_PITCH].neg   = fin_side.sp[ARG_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            prep_valid_reg <= sq_valid[ROOT_STEPS];
            out_valid_reg  <= cv[CORDIC_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prep_reg    <= prep_next;
            roll_reg    <= roll_next;
            pitch_reg   <= pitch_next;
            yaw_reg     <= yaw_next;
            clamped_reg <= cl[CORDIC_STAGES][LANE_PITCH].clamp;
        end
    end

    assign cv[0] = prep_valid_reg;
    assign cl[0] = prep_reg;

    for (genvar s = 0; s < CORDIC_STAGES; s++)
    begin : g_cordic
        q2e_cordic_cell #(
            .IDX (s)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (cv[s]),
            .in_lane   (cl[s]),
            .out_valid (cv[s+1]),
            .out_lane  (cl[s+1])
        );
    end

    always_comb
    begin
        roll_next  = to_angle(cl[CORDIC_STAGES][LANE_ROLL], PI_Q13);
        yaw_next   = to_angle(cl[CORDIC_STAGES][LANE_YAW], PI_Q13);
        if (cl[CORDIC_STAGES][LANE_PITCH].clamp)
            pitch_wide = cl[CORDIC_STAGES][LANE_PITCH].neg ? -HALF_PI_Q13 : HALF_PI_Q13;
        else
            pitch_wide = to_angle(cl[CORDIC_STAGES][LANE_PITCH], HALF_PI_Q13);
        pitch_next = pitch_wide[PITCH_W-1:0];
    end

    assign euler_valid   = out_valid_reg;
    assign roll          = roll_reg;
    assign pitch         = pitch_reg;
    assign yaw           = yaw_reg;
    assign pitch_clamped = clamped_reg;

endmodule

@@ rtl/q2e_checker.sv @@
// port-level checks for quaternion_to_euler, bound to the top level
// depends on q2e_pkg and quaternion_to_euler_assert.svh
`timescale 1ns / 1ps

`include "quaternion_to_euler_assert.svh"

module q2e_checker
    import q2e_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      quat_valid,
    input logic                      quat_ready,
    input logic                      euler_valid,
    input logic                      euler_ready,
    input logic signed [ANG_W-1:0]   roll,
    input logic signed [PITCH_W-1:0] pitch,
    input logic signed [ANG_W-1:0]   yaw,
    input logic                      pitch_clamped
);

    `Q2E_ASSERT_NXT(a_out_hold, euler_valid && !euler_ready, euler_valid && $stable(roll) && $stable(pitch) && $stable(yaw) && $stable(pitch_clamped), "euler item changed while stalled")

    `Q2E_ASSERT_IMP(a_stall_blocks_input, quat_valid && euler_valid && !euler_ready, !quat_ready, "item taken while output stalled")

    `Q2E_ASSERT_IMP(a_clamp_value, euler_valid && pitch_clamped, pitch == HALF_PI_Q13 || pitch == -HALF_PI_Q13, "clamped pitch not at half pi")

    `Q2E_ASSERT_IMP(a_angle_range, euler_valid, roll <= PI_Q13 && roll >= -PI_Q13 && yaw <= PI_Q13 && yaw >= -PI_Q13 && pitch <= HALF_PI_Q13 && pitch >= -HALF_PI_Q13, "angle out of range")

endmodule

bind quaternion_to_euler q2e_checker u_q2e_checker (.*);
